// ===== rtl/ssp_pkg.sv =====
// Shared types, constants and graph functions of the simplex subdivision pattern block.
package ssp_pkg;

  localparam int NPTS   = 10;
  localparam int NEDGE  = 6;
  localparam int NFACE  = 4;
  localparam int MAXOUT = 8;

  localparam logic [1:0] DIM_TRI = 2'd2;
  localparam logic [1:0] DIM_TET = 2'd3;

  localparam int REG_DIMENSION = 0;

  typedef logic [3:0]      pt_t;
  typedef logic [1:0]      vtx_t;
  typedef logic [NPTS-1:0] row_t;
  typedef row_t [NPTS-1:0] graph_t;

  typedef struct packed {
    pt_t a;
    pt_t b;
    pt_t c;
    pt_t d;
  } tet_t;

  // end vertices of each local edge
  localparam vtx_t EDGE_A [NEDGE] = '{2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
  localparam vtx_t EDGE_B [NEDGE] = '{2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1};

  // edges lying on face f (face opposite vertex f)
  localparam logic [NEDGE-1:0] FACE_EDGE_SET [NFACE] =
    '{6'b000111, 6'b011001, 6'b101010, 6'b110100};

  typedef struct packed {
    logic       capture;
    logic       build;
    logic       enum_step;
    logic       load_out;
    logic [2:0] sel;
  } ssp_cmd_t;

  typedef struct packed {
    logic fail;
    logic enum_done;
    logic tet;
    pt_t  count;
  } ssp_stat_t;

  function automatic graph_t build_graph(logic [NEDGE-1:0] marks, logic [3:0][2:0] le);
    graph_t g;
    pt_t    a;
    pt_t    b;
    pt_t    m;
    pt_t    o;
    pt_t    n;
    vtx_t   fj;
    vtx_t   fk;
    g = '0;
    for (int e = 0; e < NEDGE; e++) begin
      a = {2'b00, EDGE_A[e]};
      b = {2'b00, EDGE_B[e]};
      m = 4'(e + 4);
      o = 4'(9 - e);
      if (!marks[e]) begin
        g[a][b] = 1'b1;
        g[b][a] = 1'b1;
      end else begin
        g[a][m] = 1'b1;
        g[m][a] = 1'b1;
        g[b][m] = 1'b1;
        g[m][b] = 1'b1;
        for (int j = 0; j < 2; j++) begin
          fj = (j == 0) ? EDGE_A[NEDGE-1-e] : EDGE_B[NEDGE-1-e];
          fk = (j == 0) ? EDGE_B[NEDGE-1-e] : EDGE_A[NEDGE-1-e];
          if (le[fj] == 3'(e)) begin
            g[{2'b00, fk}][m] = 1'b1;
            g[m][{2'b00, fk}] = 1'b1;
            if (le[fk] == 3'(e) && marks[NEDGE-1-e]) begin
              g[m][o] = 1'b1;
              g[o][m] = 1'b1;
            end
          end else begin
            n = {1'b0, le[fj]} + 4'd4;
            if (n < 4'(NPTS)) begin
              g[n][m] = 1'b1;
              g[m][n] = 1'b1;
            end
          end
        end
      end
    end
    return g;
  endfunction

  function automatic pt_t low_bit(row_t v);
    pt_t r;
    r = '0;
    for (int i = NPTS - 1; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  // points strictly between lo and hi
  function automatic row_t between(pt_t lo, pt_t hi);
    row_t r;
    for (int c = 0; c < NPTS; c++) begin
      r[c] = (4'(c) > lo) && (4'(c) < hi);
    end
    return r;
  endfunction

endpackage

// ===== rtl/ssp_ctrl.sv =====
// Sequencing state machine: capture, graph build, clique walk and result hand-off.
module ssp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ssp_pkg::ssp_cmd_t cmd,
  input  ssp_pkg::ssp_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_BUILD, S_ENUM, S_EMIT} state_t;

  state_t     state;
  logic [2:0] idx;
  logic       last;
  logic       load;

  assign in_ready = (state == S_IDLE);
  assign last     = ({1'b0, idx} == (stat.count - 4'd1));
  assign load     = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.capture   = in_valid && in_ready;
    cmd.build     = (state == S_BUILD);
    cmd.enum_step = (state == S_ENUM);
    cmd.load_out  = load;
    cmd.sel       = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_BUILD;
        end
        S_BUILD: begin
          state <= S_ENUM;
        end
        S_ENUM: begin
          if (!stat.tet || stat.enum_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            if (last) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ssp_dp.sv =====
// Datapath: input capture, precondition checks, connection graph, clique walk and output word.
module ssp_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         dimension,
  input  logic [5:0]         edge_marks,
  input  logic [2:0]         long_edge_face0,
  input  logic [2:0]         long_edge_face1,
  input  logic [2:0]         long_edge_face2,
  input  logic [2:0]         long_edge_face3,
  input  logic               uniform_ok,
  input  ssp_pkg::ssp_cmd_t  cmd,
  output ssp_pkg::ssp_stat_t stat,
  output logic [3:0]         corner_a,
  output logic [3:0]         corner_b,
  output logic [3:0]         corner_c,
  output logic [3:0]         corner_d,
  output logic               final_simplex,
  input  logic               out_last,
  output logic               input_error
);

  logic [5:0]        marks;
  logic [3:0][2:0]   le;
  logic              uni;
  logic              tet;
  logic              bad_dim;
  logic              fail_r;
  ssp_pkg::graph_t   g;

  ssp_pkg::pt_t      pi;
  ssp_pkg::pt_t      pj;
  ssp_pkg::pt_t      qi;
  ssp_pkg::pt_t      qj;
  ssp_pkg::pt_t      ck;
  ssp_pkg::row_t     kmask;
  ssp_pkg::row_t     cmask;
  logic              pairs_left;
  ssp_pkg::pt_t      cnt;
  logic              ovf;
  ssp_pkg::tet_t     clq [ssp_pkg::MAXOUT];

  // checks
  logic              fail2;
  logic              fail3;
  logic [7:0]        marks8;
  logic [7:0]        fe8;

  always_comb begin
    marks8 = {2'b00, marks};
    fail2  = (le[0] > 3'd2) || !marks8[le[0]];
    fail3  = 1'b0;
    for (int f = 0; f < ssp_pkg::NFACE; f++) begin
      fe8 = {2'b00, ssp_pkg::FACE_EDGE_SET[f]};
      if (le[f] > 3'd5 || !fe8[le[f]]) fail3 = 1'b1;
      if ((|(ssp_pkg::FACE_EDGE_SET[f] & marks)) && !marks8[le[f]]) fail3 = 1'b1;
    end
  end

  // clique walk combinational terms
  ssp_pkg::row_t gi;
  ssp_pkg::row_t gj;
  ssp_pkg::row_t qgi;
  ssp_pkg::row_t qgj;
  ssp_pkg::row_t kset;
  ssp_pkg::pt_t  knext;
  ssp_pkg::pt_t  cnext;
  logic          last_pair;

  always_comb begin
    gi    = g[pi];
    gj    = g[pj];
    qgi   = g[qi];
    qgj   = g[qj];
    kset  = '0;
    for (int k = 0; k < ssp_pkg::NPTS; k++) begin
      kset[k] = g[pi][pj] && gi[k] && gj[k] &&
                (|(gi & gj & g[k] & ssp_pkg::between(pj, 4'(k))));
    end
    knext     = ssp_pkg::low_bit(kmask);
    cnext     = ssp_pkg::low_bit(cmask);
    last_pair = (pi == 4'd8) && (pj == 4'd9);
  end

  // triangle pattern
  logic [1:0]    v0;
  logic [1:0]    v1;
  logic [1:0]    v2;
  ssp_pkg::pt_t  e0;
  ssp_pkg::pt_t  e1;
  ssp_pkg::pt_t  e2;
  logic          m0;
  logic          m1;
  logic          uni_split;
  ssp_pkg::tet_t h1 [2];
  ssp_pkg::tet_t h2 [2];
  ssp_pkg::tet_t tri_word;
  ssp_pkg::pt_t  n1;
  ssp_pkg::pt_t  tri_cnt;
  logic [2:0]    k2;

  always_comb begin
    case (le[0])
      3'd0:    begin v0 = 2'd1; v1 = 2'd2; end
      3'd1:    begin v0 = 2'd2; v1 = 2'd0; end
      default: begin v0 = 2'd0; v1 = 2'd1; end
    endcase
    v2 = le[0][1:0];
    e0 = {2'b00, v0} + 4'd3;
    e1 = {2'b00, v1} + 4'd3;
    e2 = {2'b00, v2} + 4'd3;
    m0 = marks[v0];
    m1 = marks[v1];
    uni_split = uni && m0 && m1;
    if (m0) begin
      h1[0] = '{e2, {2'b00, v2}, e0, 4'd0};
      h1[1] = '{e2, e0, {2'b00, v1}, 4'd0};
    end else begin
      h1[0] = '{e2, {2'b00, v2}, {2'b00, v1}, 4'd0};
      h1[1] = h1[0];
    end
    if (m1) begin
      h2[0] = '{e2, {2'b00, v2}, e1, 4'd0};
      h2[1] = '{e2, e1, {2'b00, v0}, 4'd0};
    end else begin
      h2[0] = '{e2, {2'b00, v2}, {2'b00, v0}, 4'd0};
      h2[1] = h2[0];
    end
    n1      = m0 ? 4'd2 : 4'd1;
    tri_cnt = uni_split ? 4'd4 : (n1 + (m1 ? 4'd2 : 4'd1));
    k2      = cmd.sel - n1[2:0];
    if (uni_split) begin
      case (cmd.sel[1:0])
        2'd0:    tri_word = '{e0, e1, {2'b00, v2}, 4'd0};
        2'd1:    tri_word = '{e1, e2, {2'b00, v0}, 4'd0};
        2'd2:    tri_word = '{e2, e0, {2'b00, v1}, 4'd0};
        default: tri_word = '{e2, e1, e0, 4'd0};
      endcase
    end else if ({1'b0, cmd.sel} < n1) begin
      tri_word = h1[cmd.sel[0]];
    end else begin
      tri_word = h2[k2[0]];
    end
  end

  logic fail_all;
  assign fail_all = fail_r || (tet && (ovf || cnt == 4'd0));

  always_comb begin
    stat           = '0;
    stat.fail      = fail_all;
    stat.tet       = tet && !fail_r;
    stat.enum_done = ovf || (!pairs_left && kmask == '0 && cmask == '0);
    stat.count     = fail_all ? 4'd1 : (tet ? cnt : tri_cnt);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      marks   <= edge_marks;
      le      <= {long_edge_face3, long_edge_face2, long_edge_face1, long_edge_face0};
      uni     <= uniform_ok;
      tet     <= (dimension == ssp_pkg::DIM_TET);
      bad_dim <= (dimension != ssp_pkg::DIM_TRI) && (dimension != ssp_pkg::DIM_TET);
    end
    if (cmd.build) begin
      g <= ssp_pkg::build_graph(marks, le);
    end
    if (cmd.load_out) begin
      if (fail_all) begin
        corner_a      <= '0;
        corner_b      <= '0;
        corner_c      <= '0;
        corner_d      <= '0;
        final_simplex <= 1'b1;
        input_error   <= 1'b1;
      end else begin
        corner_a      <= tet ? clq[cmd.sel].a : tri_word.a;
        corner_b      <= tet ? clq[cmd.sel].b : tri_word.b;
        corner_c      <= tet ? clq[cmd.sel].c : tri_word.c;
        corner_d      <= tet ? clq[cmd.sel].d : 4'd0;
        final_simplex <= out_last;
        input_error   <= 1'b0;
      end
    end
    if (rst) begin
      fail_r     <= 1'b0;
      pairs_left <= 1'b0;
      kmask      <= '0;
      cmask      <= '0;
      cnt        <= '0;
      ovf        <= 1'b0;
      pi         <= '0;
      pj         <= 4'd1;
    end else if (cmd.build) begin
      fail_r     <= bad_dim || (tet ? fail3 : fail2);
      pairs_left <= 1'b1;
      kmask      <= '0;
      cmask      <= '0;
      cnt        <= '0;
      ovf        <= 1'b0;
      pi         <= '0;
      pj         <= 4'd1;
    end else if (cmd.enum_step) begin
      if (cmask != '0) begin
        if (cnt == 4'(ssp_pkg::MAXOUT)) begin
          ovf <= 1'b1;
        end else begin
          clq[cnt[2:0]] <= '{qi, qj, cnext, ck};
          cnt           <= cnt + 4'd1;
        end
        cmask[cnext] <= 1'b0;
      end else if (kmask != '0) begin
        cmask        <= qgi & qgj & g[knext] & ssp_pkg::between(qj, knext);
        ck           <= knext;
        kmask[knext] <= 1'b0;
      end else if (pairs_left) begin
        kmask <= kset;
        qi    <= pi;
        qj    <= pj;
        if (last_pair) begin
          pairs_left <= 1'b0;
        end else if (pj == 4'd9) begin
          pi <= pi + 4'd1;
          pj <= pi + 4'd2;
        end else begin
          pj <= pj + 4'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/simplex_subdivision_pattern_top.sv =====
// Top level of the simplex subdivision pattern block: register port, controller and datapath.
//
// One input word describes one cell: marked edges, the longest edge of each
// face and the uniform-split flag. The block answers with the sub-simplices
// of the bisection pattern, one output word per simplex, final_simplex set on
// the last word of the cell; a cell that breaks the preconditions gives one
// word with input_error set and all corners zero.
// Both channels use valid/ready. A cell is accepted only when the block is
// idle; the previous cell's last word may still sit in the output register.
// Triangle mode: a build step and a check step, then one word per cycle while
// the receiver is ready (up to 4).
// Tetrahedron mode: a build step, then a clique walk over the 45 point
// pairs that steps through each pair, each candidate fourth point and each
// sub-tetrahedron in turn, then a finishing step, then one word per cycle
// while the receiver is ready (up to 8).
// When the receiver stalls, the output register holds its word and emission
// waits; nothing is dropped.
// The dimension register sits at address 0 and resets to 3 (tetrahedra);
// synchronous reset also returns the controller to idle with no word pending.
module simplex_subdivision_pattern_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  edge_marks,
  input  logic [2:0]  long_edge_face0,
  input  logic [2:0]  long_edge_face1,
  input  logic [2:0]  long_edge_face2,
  input  logic [2:0]  long_edge_face3,
  input  logic        uniform_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  corner_a,
  output logic [3:0]  corner_b,
  output logic [3:0]  corner_c,
  output logic [3:0]  corner_d,
  output logic        final_simplex,
  output logic        input_error
);

  logic [1:0]         dimension;
  ssp_pkg::ssp_cmd_t  cmd;
  ssp_pkg::ssp_stat_t stat;
  logic               out_last;

  assign pready   = 1'b1;
  assign prdata   = {30'd0, dimension};
  assign out_last = ({1'b0, cmd.sel} == (stat.count - 4'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= ssp_pkg::DIM_TET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[1:0] == 2'(ssp_pkg::REG_DIMENSION * 4))) begin
      dimension <= pwdata[1:0];
    end
  end

  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ssp_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .dimension       (dimension),
    .edge_marks      (edge_marks),
    .long_edge_face0 (long_edge_face0),
    .long_edge_face1 (long_edge_face1),
    .long_edge_face2 (long_edge_face2),
    .long_edge_face3 (long_edge_face3),
    .uniform_ok      (uniform_ok),
    .cmd             (cmd),
    .stat            (stat),
    .corner_a        (corner_a),
    .corner_b        (corner_b),
    .corner_c        (corner_c),
    .corner_d        (corner_d),
    .final_simplex   (final_simplex),
    .out_last        (out_last),
    .input_error     (input_error)
  );

endmodule

// ===== tb/simplex_subdivision_pattern_top_tb.sv =====
// Self-checking testbench for simplex_subdivision_pattern_top with a built-in subdivision predictor.
module simplex_subdivision_pattern_top_tb;

  localparam logic [1:0] DIM_BAD_LO = 2'd0;
  localparam logic [1:0] DIM_BAD_HI = 2'd1;

  // edge end vertices, edge 0 in the low slot
  localparam logic [5:0][1:0] END_LO = {2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [5:0][1:0] END_HI = {2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  typedef struct packed {
    logic [5:0]      marks;
    logic [3:0][2:0] le;
    logic            uni;
  } cell_t;

  typedef struct packed {
    ssp_pkg::pt_t a;
    ssp_pkg::pt_t b;
    ssp_pkg::pt_t c;
    ssp_pkg::pt_t d;
    logic         fin;
    logic         err;
  } simplex_word_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [5:0]  edge_marks;
  logic [2:0]  long_edge_face0;
  logic [2:0]  long_edge_face1;
  logic [2:0]  long_edge_face2;
  logic [2:0]  long_edge_face3;
  logic        uniform_ok;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  corner_a;
  logic [3:0]  corner_b;
  logic [3:0]  corner_c;
  logic [3:0]  corner_d;
  logic        final_simplex;
  logic        input_error;

  simplex_word_t expected_simplices [$];
  logic [1:0]    dimension_shadow;
  int            mismatches;
  int            cells_sent;
  int            words_seen;
  int            error_words;
  int            burst_left;

  simplex_subdivision_pattern_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("timeout: words still outstanding = %0d", expected_simplices.size());
    $display("FAIL");
    $finish;
  end

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic string word_text(simplex_word_t w);
    return $sformatf("(%0d,%0d,%0d,%0d) fin=%0d err=%0d", w.a, w.b, w.c, w.d, w.fin, w.err);
  endfunction

  function automatic void expect_simplex(int a, int b, int c, int d, bit fin, bit err);
    simplex_word_t w;
    w.a   = 4'(a);
    w.b   = 4'(b);
    w.c   = 4'(c);
    w.d   = 4'(d);
    w.fin = fin;
    w.err = err;
    expected_simplices.insert(expected_simplices.size(), w);
  endfunction

  function automatic logic [5:0] face_mask(int f);
    logic [5:0] m;
    for (int e = 0; e < 6; e++) m[e] = (END_LO[e] != f) && (END_HI[e] != f);
    return m;
  endfunction

  function automatic logic [9:0][9:0] join_pts(logic [9:0][9:0] g, int a, int b);
    g[a][b] = 1'b1;
    g[b][a] = 1'b1;
    return g;
  endfunction

  function automatic void split_triangle(cell_t cl);
    logic [2:0]  m;
    logic [11:0] tris [4];
    int          le, v0, v1, v2, e0, e1, e2, n;
    m  = cl.marks[2:0];
    le = cl.le[0];
    if (le > 2 || !m[le]) begin
      expect_simplex(0, 0, 0, 0, 1, 1);
      return;
    end
    v0 = (le + 1) % 3;
    v1 = (le + 2) % 3;
    v2 = le;
    e0 = v0 + 3;
    e1 = v1 + 3;
    e2 = v2 + 3;
    if (cl.uni && m[v0] && m[v1]) begin
      expect_simplex(e0, e1, v2, 0, 0, 0);
      expect_simplex(e1, e2, v0, 0, 0, 0);
      expect_simplex(e2, e0, v1, 0, 0, 0);
      expect_simplex(e2, e1, e0, 0, 1, 0);
      return;
    end
    n = 0;
    if (m[v0]) begin
      tris[n] = {4'(e2), 4'(v2), 4'(e0)};
      n++;
      tris[n] = {4'(e2), 4'(e0), 4'(v1)};
      n++;
    end else begin
      tris[n] = {4'(e2), 4'(v2), 4'(v1)};
      n++;
    end
    if (m[v1]) begin
      tris[n] = {4'(e2), 4'(v2), 4'(e1)};
      n++;
      tris[n] = {4'(e2), 4'(e1), 4'(v0)};
      n++;
    end else begin
      tris[n] = {4'(e2), 4'(v2), 4'(v0)};
      n++;
    end
    for (int k = 0; k < n; k++) begin
      expect_simplex(tris[k][11:8], tris[k][7:4], tris[k][3:0], 0, k == n - 1, 0);
    end
  endfunction

  function automatic void split_tetrahedron(cell_t cl);
    logic [9:0][9:0] g;
    logic [15:0]     tet [8];
    int              cand [10];
    int              le [4];
    int              n, nc, opp, fj, fk;
    for (int f = 0; f < 4; f++) le[f] = cl.le[f];
    for (int f = 0; f < 4; f++) begin
      if (le[f] > 5 || END_LO[le[f]] == f || END_HI[le[f]] == f ||
          ((cl.marks & face_mask(f)) != 0 && !cl.marks[le[f]])) begin
        expect_simplex(0, 0, 0, 0, 1, 1);
        return;
      end
    end
    g = '0;
    for (int e = 0; e < 6; e++) begin
      opp = 5 - e;
      if (!cl.marks[e]) begin
        g = join_pts(g, END_LO[e], END_HI[e]);
      end else begin
        g = join_pts(g, END_LO[e], e + 4);
        g = join_pts(g, END_HI[e], e + 4);
        for (int j = 0; j < 2; j++) begin
          fj = (j == 0) ? END_LO[opp] : END_HI[opp];
          fk = (j == 0) ? END_HI[opp] : END_LO[opp];
          if (le[fj] == e) begin
            g = join_pts(g, fk, e + 4);
            if (le[fk] == e && cl.marks[opp]) g = join_pts(g, e + 4, opp + 4);
          end else begin
            g = join_pts(g, le[fj] + 4, e + 4);
          end
        end
      end
    end
    // 4-cliques: pair (i,j), then each common neighbor k against earlier ones
    n = 0;
    for (int i = 0; i < 10; i++) begin
      for (int j = i + 1; j < 10; j++) begin
        if (!g[i][j]) continue;
        nc = 0;
        for (int k = j + 1; k < 10; k++) begin
          if (!(g[i][k] && g[j][k])) continue;
          for (int q = 0; q < nc; q++) begin
            if (!g[cand[q]][k]) continue;
            if (n >= 8) begin
              expect_simplex(0, 0, 0, 0, 1, 1);
              return;
            end
            tet[n] = {4'(i), 4'(j), 4'(cand[q]), 4'(k)};
            n++;
          end
          cand[nc] = k;
          nc++;
        end
      end
    end
    if (n == 0) begin
      expect_simplex(0, 0, 0, 0, 1, 1);
      return;
    end
    for (int r = 0; r < n; r++) begin
      expect_simplex(tet[r][15:12], tet[r][11:8], tet[r][7:4], tet[r][3:0], r == n - 1, 0);
    end
  endfunction

  function automatic void plan_subdivision(cell_t cl);
    if (dimension_shadow == ssp_pkg::DIM_TRI) split_triangle(cl);
    else if (dimension_shadow == ssp_pkg::DIM_TET) split_tetrahedron(cl);
    else expect_simplex(0, 0, 0, 0, 1, 1);
  endfunction

  function automatic cell_t make_cell(logic [5:0] marks, int l0, int l1, int l2, int l3,
                                      logic uni);
    cell_t cl;
    cl.marks = marks;
    cl.le[0] = 3'(l0);
    cl.le[1] = 3'(l1);
    cl.le[2] = 3'(l2);
    cl.le[3] = 3'(l3);
    cl.uni   = uni;
    return cl;
  endfunction

  function automatic cell_t random_tet_cell();
    cell_t      cl;
    logic [5:0] on_f;
    int         pick, f;
    cl.marks = 6'($urandom);
    for (int i = 0; i < 4; i++) cl.le[i] = 3'($urandom);
    cl.uni = 1'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 3) return cl;
    for (int i = 0; i < 4; i++) begin
      on_f = face_mask(i);
      do cl.le[i] = 3'($urandom_range(0, 5)); while (!on_f[cl.le[i]]);
    end
    case ($urandom_range(0, 5))
      0: cl.marks = '0;
      1: cl.marks = '1;
      2: cl.marks = 6'(1 << $urandom_range(0, 5));
      default: cl.marks = 6'($urandom);
    endcase
    // a face with any marked edge must have its longest edge marked
    repeat (4) begin
      for (int i = 0; i < 4; i++) begin
        if ((cl.marks & face_mask(i)) != 0) cl.marks[cl.le[i]] = 1'b1;
      end
    end
    if (pick < 5) begin
      f    = $urandom_range(0, 3);
      on_f = face_mask(f);
      case ($urandom_range(0, 2))
        0: cl.le[f] = 3'($urandom_range(6, 7));
        1: do cl.le[f] = 3'($urandom_range(0, 5)); while (on_f[cl.le[f]]);
        default: begin
          cl.marks = cl.marks | on_f;
          cl.marks[cl.le[f]] = 1'b0;
        end
      endcase
    end
    return cl;
  endfunction

  function automatic cell_t random_tri_cell();
    cell_t cl;
    cl.marks = 6'($urandom);
    for (int i = 0; i < 4; i++) cl.le[i] = 3'($urandom);
    cl.uni = 1'($urandom);
    if ($urandom_range(0, 6) != 0) cl.le[0] = 3'($urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) begin
      cl.marks[2:0] = 3'b111;
    end else if (cl.le[0] <= 2 && $urandom_range(0, 7) != 0) begin
      cl.marks[cl.le[0]] = 1'b1;
    end
    return cl;
  endfunction

  task automatic send_cell(cell_t cl);
    in_valid        <= 1'b1;
    edge_marks      <= cl.marks;
    long_edge_face0 <= cl.le[0];
    long_edge_face1 <= cl.le[1];
    long_edge_face2 <= cl.le[2];
    long_edge_face3 <= cl.le[3];
    uniform_ok      <= cl.uni;
    do @(posedge clk); while (!in_ready);
    plan_subdivision(cl);
    cells_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (expected_simplices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_dimension();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 2'(4 * ssp_pkg::REG_DIMENSION);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(dimension_shadow)) begin
      note_mismatch($sformatf("dimension reads %0d, expected %0d", prdata, dimension_shadow));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_dimension(logic [1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(4 * ssp_pkg::REG_DIMENSION);
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dimension_shadow = value;
    read_dimension();
  endtask

  task automatic test_register_reset();
    read_dimension();
  endtask

  task automatic test_tet_corner_cases();
    send_cell(make_cell(6'b000000, 0, 0, 1, 2, 0));
    send_cell(make_cell(6'b000001, 0, 0, 1, 2, 0));
    send_cell(make_cell(6'b111111, 0, 0, 1, 2, 1));
    send_cell(make_cell(6'b111111, 2, 4, 5, 5, 0));
    send_cell(make_cell(6'b111111, 6, 0, 1, 2, 0));
    send_cell(make_cell(6'b000000, 0, 0, 1, 7, 1));
    send_cell(make_cell(6'b000000, 5, 0, 1, 2, 0));
    send_cell(make_cell(6'b000010, 0, 0, 1, 2, 0));
    drain_words();
  endtask

  task automatic test_tri_corner_cases();
    write_dimension(ssp_pkg::DIM_TRI);
    send_cell(make_cell(6'b000000, 0, 0, 0, 0, 0));
    send_cell(make_cell(6'b000001, 0, 0, 0, 0, 0));
    send_cell(make_cell(6'b000010, 1, 0, 0, 0, 1));
    send_cell(make_cell(6'b000100, 2, 0, 0, 0, 0));
    send_cell(make_cell(6'b000111, 1, 0, 0, 0, 1));
    send_cell(make_cell(6'b000111, 2, 0, 0, 0, 0));
    send_cell(make_cell(6'b111001, 0, 7, 7, 7, 1));
    send_cell(make_cell(6'b111111, 3, 0, 0, 0, 1));
    send_cell(make_cell(6'b111111, 7, 7, 7, 7, 1));
    send_cell(make_cell(6'b000110, 0, 0, 0, 0, 1));
    send_cell(make_cell(6'b000101, 2, 0, 0, 0, 1));
    drain_words();
  endtask

  task automatic test_bad_dimension();
    write_dimension(DIM_BAD_LO);
    send_cell(make_cell(6'b111111, 0, 0, 1, 2, 0));
    send_cell(make_cell(6'b000111, 1, 0, 0, 0, 1));
    drain_words();
    write_dimension(DIM_BAD_HI);
    send_cell(make_cell(6'b000000, 0, 0, 1, 2, 0));
    send_cell(make_cell(6'b000001, 0, 0, 0, 0, 1));
    drain_words();
  endtask

  task automatic test_random_triangles(int count);
    write_dimension(ssp_pkg::DIM_TRI);
    repeat (count) send_cell(random_tri_cell());
    drain_words();
  endtask

  task automatic test_random_tetrahedra(int count);
    write_dimension(ssp_pkg::DIM_TET);
    repeat (count) send_cell(random_tet_cell());
    drain_words();
  endtask

  initial begin : drain_pattern
    int mode;
    int hold;
    mode = 0;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(10, 80);
      end
      hold--;
      case (mode)
        0, 1: out_ready <= 1'b1;
        2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_words
    simplex_word_t seen;
    simplex_word_t want;
    if (!rst && out_valid && out_ready) begin
      seen = {corner_a, corner_b, corner_c, corner_d, final_simplex, input_error};
      words_seen++;
      if (input_error) error_words++;
      if (expected_simplices.size() == 0) begin
        note_mismatch($sformatf("unexpected word %s", word_text(seen)));
      end else begin
        want = expected_simplices.pop_front();
        if (seen.a !== want.a || seen.b !== want.b || seen.c !== want.c ||
            seen.d !== want.d || seen.fin !== want.fin || seen.err !== want.err) begin
          note_mismatch($sformatf("expected %s, got %s", word_text(want), word_text(seen)));
        end
      end
    end
  end

  initial begin
    mismatches       = 0;
    cells_sent       = 0;
    words_seen       = 0;
    error_words      = 0;
    burst_left       = 0;
    dimension_shadow = ssp_pkg::DIM_TET;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid        <= 1'b0;
    edge_marks      <= '0;
    long_edge_face0 <= '0;
    long_edge_face1 <= '0;
    long_edge_face2 <= '0;
    long_edge_face3 <= '0;
    uniform_ok      <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_tet_corner_cases();
    test_tri_corner_cases();
    test_bad_dimension();
    test_random_triangles(125);
    test_random_tetrahedra(220);
    repeat (40) @(posedge clk);
    if (expected_simplices.size() != 0) begin
      $display("%0d expected words never arrived", expected_simplices.size());
      mismatches += expected_simplices.size();
    end
    $display("%0d cells across dimensions 0..3, %0d simplex words checked (%0d error words)",
             cells_sent, words_seen, error_words);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== simplex_subdivision_pattern_top.f =====
rtl/ssp_pkg.sv
rtl/ssp_ctrl.sv
rtl/ssp_dp.sv
rtl/simplex_subdivision_pattern_top.sv
tb/simplex_subdivision_pattern_top_tb.sv
